### rtl/plim_pkg.sv
// Shared constants, codes and helper functions of the priority level interrupt masker.
`timescale 1ns / 1ps
`default_nettype none

package plim_pkg;

  localparam int NUM_VECTORS = 32;
  localparam int NUM_LEVELS  = 16;
  localparam int NEST_DEPTH  = 16;

  localparam int MASK_W = 32;
  localparam int VEC_W  = 5;
  localparam int LVL_W  = 4;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  localparam int VL_AW  = $clog2(NUM_VECTORS);
  localparam int LM_AW  = $clog2(NUM_LEVELS);
  localparam int SV_AW  = $clog2(NEST_DEPTH);
  localparam int DEP_W  = $clog2(NEST_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_ENABLE  = 3'd0,
    FN_DISABLE = 3'd1,
    FN_TRIGGER = 3'd2,
    FN_ENTRY   = 3'd3,
    FN_EXIT    = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_OVF  = 2'd2,
    ST_UNF  = 2'd3
  } status_t;

  // Top NUM_VECTORS bits of a mask word; vector 0 sits at the MSB.
  function automatic logic [MASK_W-1:0] plim_valid_lines();
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_VECTORS; i++) begin
      m[MASK_W-1-i] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [MASK_W-1:0] VALID_LINES = plim_valid_lines();

  // Number of the first set bit counted from the MSB.
  function automatic logic [VEC_W-1:0] plim_first_set(input logic [MASK_W-1:0] w);
    logic [VEC_W-1:0] f;
    f = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (w[i]) begin
        f = VEC_W'(MASK_W - 1 - i);
      end
    end
    return f;
  endfunction

  function automatic logic [MASK_W-1:0] plim_line_bit(input logic [VEC_W-1:0] v);
    return MASK_W'(32'h8000_0000) >> v;
  endfunction

endpackage

`default_nettype wire

### rtl/plim_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module plim_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the contents from before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/priority_level_interrupt_masker.sv
// Priority level interrupt masker: nested-priority mask tables and entry/exit sequencing.
//
// Usage: one request beat on the in_ channel (valid/ready) selects a function by
// in_func: enable a vector at a level, disable a vector, set its trigger mode,
// take an interrupt entry from a pending-status word, or take an interrupt exit.
// Every request beat yields exactly one result beat on the out_ channel with
// the enable mask of the current level, the vector found at entry, the current
// level, the trigger bits and a status code.
// Requests are handled one at a time. Enable and disable walk the level masks
// below the vector's level (up to 15) through the single write port of the
// level-mask RAM, one level per cycle; the vector-level and saved-level RAMs
// have registered read data.
// Reset clears the current level, nesting depth and trigger bits, and the
// valid bits that make the level masks and vector levels read as zero.
// No clearing pass is needed. The result sits in an output register; while
// the receiver stalls it holds, and the next request may already be accepted
// and worked on until its own result is ready.
`timescale 1ns / 1ps
`default_nettype none

module priority_level_interrupt_masker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [plim_pkg::FUNC_W-1:0] in_func,
  input  logic [plim_pkg::VEC_W-1:0]  in_vector,
  input  logic [plim_pkg::LVL_W-1:0]  in_level,
  input  logic [plim_pkg::MASK_W-1:0] in_pending_status,
  input  logic                        in_edge_mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [plim_pkg::MASK_W-1:0] out_enable_mask,
  output logic [plim_pkg::VEC_W-1:0]  out_found_vector,
  output logic [plim_pkg::LVL_W-1:0]  out_current_level_out,
  output logic [plim_pkg::MASK_W-1:0] out_trigger_mask,
  output logic [plim_pkg::STAT_W-1:0] out_status
);

  import plim_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_VREAD, S_SREAD, S_WALK, S_FRD, S_FOUT
  } state_t;

  localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(NUM_LEVELS - 1);

  state_t            state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [VEC_W-1:0]  vec_r, vec_nxt;
  logic [MASK_W-1:0] pend_r, pend_nxt;
  logic              set_r, set_nxt;
  logic [LVL_W-1:0]  cur_r, cur_nxt;
  logic [DEP_W-1:0]  depth_r, depth_nxt;
  logic [MASK_W-1:0] trig_r, trig_nxt;
  logic [NUM_LEVELS-1:0]  lm_vld_r, lm_vld_nxt;
  logic [NUM_VECTORS-1:0] vl_vld_r, vl_vld_nxt;
  logic [VEC_W-1:0]  found_r, found_nxt;
  status_t           status_r, status_nxt;
  logic [LVL_W-1:0]  n_r, n_nxt;
  logic [LVL_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [LM_AW-1:0]  wr_addr_r, wr_addr_nxt;
  logic [VL_AW-1:0]  vl_addr_r, vl_addr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r, out_mask_nxt;
  logic [VEC_W-1:0]  out_found_r, out_found_nxt;
  logic [LVL_W-1:0]  out_lvl_r, out_lvl_nxt;
  logic [MASK_W-1:0] out_trig_r, out_trig_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  // Memory ports.
  logic              lm_we, lm_re;
  logic [LM_AW-1:0]  lm_waddr, lm_raddr;
  logic [MASK_W-1:0] lm_wdata, lm_q;
  logic              vl_we, vl_re;
  logic [VL_AW-1:0]  vl_waddr, vl_raddr;
  logic [LVL_W-1:0]  vl_wdata, vl_q;
  logic              sv_we, sv_re;
  logic [SV_AW-1:0]  sv_waddr, sv_raddr;
  logic [LVL_W-1:0]  sv_wdata, sv_q;

  logic              in_acc;
  logic              in_vec_ok;
  logic [LVL_W-1:0]  lvl_sat;
  logic [MASK_W-1:0] pend_vld;
  logic [LVL_W-1:0]  vl_eff;
  logic [MASK_W-1:0] lm_eff;
  logic [MASK_W-1:0] vbit;
  logic [DEP_W-1:0]  depth_dec;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_vec_ok = ({1'b0, in_vector} < (VEC_W + 1)'(NUM_VECTORS));
  assign lvl_sat   = (in_level > MAX_LVL) ? MAX_LVL : in_level;
  assign pend_vld  = pend_r & VALID_LINES;
  assign vl_eff    = vl_vld_r[vl_addr_r] ? vl_q : '0;
  assign vbit      = plim_line_bit(vec_r);
  assign depth_dec = depth_r - 1'b1;
  assign lm_eff    = (state_r == S_FOUT) ? (lm_vld_r[cur_r[LM_AW-1:0]] ? lm_q : '0)
                                         : (lm_vld_r[wr_addr_r] ? lm_q : '0);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    vec_nxt       = vec_r;
    pend_nxt      = pend_r;
    set_nxt       = set_r;
    cur_nxt       = cur_r;
    depth_nxt     = depth_r;
    trig_nxt      = trig_r;
    lm_vld_nxt    = lm_vld_r;
    vl_vld_nxt    = vl_vld_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = rd_pend_r;
    wr_addr_nxt   = wr_addr_r;
    vl_addr_nxt   = vl_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mask_nxt  = out_mask_r;
    out_found_nxt = out_found_r;
    out_lvl_nxt   = out_lvl_r;
    out_trig_nxt  = out_trig_r;
    out_stat_nxt  = out_stat_r;

    lm_we = 1'b0; lm_waddr = wr_addr_r; lm_wdata = '0;
    lm_re = 1'b0; lm_raddr = cnt_r[LM_AW-1:0];
    vl_we = 1'b0; vl_waddr = vec_r[VL_AW-1:0]; vl_wdata = '0;
    vl_re = 1'b0; vl_raddr = in_vector[VL_AW-1:0];
    sv_we = 1'b0; sv_waddr = depth_r[SV_AW-1:0]; sv_wdata = cur_r;
    sv_re = 1'b0; sv_raddr = depth_dec[SV_AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt    = in_func;
          vec_nxt     = in_vector;
          pend_nxt    = in_pending_status;
          found_nxt   = '0;
          status_nxt  = ST_OK;
          cnt_nxt     = '0;
          rd_pend_nxt = 1'b0;
          state_nxt   = S_FRD;
          case (in_func)
            FN_ENABLE: begin
              if (in_vec_ok) begin
                vl_we      = 1'b1;
                vl_waddr   = in_vector[VL_AW-1:0];
                vl_wdata   = lvl_sat;
                vl_vld_nxt[in_vector[VL_AW-1:0]] = 1'b1;
                n_nxt      = lvl_sat;
                set_nxt    = 1'b1;
                state_nxt  = S_WALK;
              end
            end
            FN_DISABLE: begin
              if (in_vec_ok) begin
                vl_re       = 1'b1;
                vl_addr_nxt = in_vector[VL_AW-1:0];
                state_nxt   = S_VREAD;
              end
            end
            FN_TRIGGER: begin
              if (in_vec_ok) begin
                if (in_edge_mode) begin
                  trig_nxt = trig_r | plim_line_bit(in_vector);
                end else begin
                  trig_nxt = trig_r & ~plim_line_bit(in_vector);
                end
              end
            end
            FN_ENTRY: begin
              state_nxt = S_FIND;
            end
            FN_EXIT: begin
              if (depth_r == '0) begin
                status_nxt = ST_UNF;
              end else begin
                sv_re     = 1'b1;
                depth_nxt = depth_dec;
                state_nxt = S_SREAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FIND: begin
        state_nxt = S_FRD;
        if (pend_vld == '0) begin
          status_nxt = ST_NONE;
        end else begin
          found_nxt = plim_first_set(pend_vld);
          if (depth_r >= DEP_W'(NEST_DEPTH)) begin
            status_nxt = ST_OVF;
          end else begin
            vl_re       = 1'b1;
            vl_raddr    = plim_first_set(pend_vld);
            vl_addr_nxt = plim_first_set(pend_vld);
            state_nxt   = S_VREAD;
          end
        end
      end
      S_VREAD: begin
        if (func_r == FN_DISABLE) begin
          vl_we      = 1'b1;
          vl_wdata   = '0;
          vl_vld_nxt[vec_r[VL_AW-1:0]] = 1'b1;
          n_nxt      = vl_eff;
          set_nxt    = 1'b0;
          state_nxt  = S_WALK;
        end else begin
          // Entry: push the current level, raise it if the vector ranks higher.
          sv_we     = 1'b1;
          depth_nxt = depth_r + 1'b1;
          if (vl_eff > cur_r) begin
            cur_nxt = vl_eff;
          end
          state_nxt = S_FRD;
        end
      end
      S_SREAD: begin
        cur_nxt   = sv_q;
        state_nxt = S_FRD;
      end
      S_WALK: begin
        // Read level cnt while writing back level cnt-1 read last cycle.
        if (rd_pend_r) begin
          lm_we    = 1'b1;
          lm_wdata = set_r ? (lm_eff | vbit) : (lm_eff & ~vbit);
          lm_vld_nxt[wr_addr_r] = 1'b1;
        end
        if (cnt_r < n_r) begin
          lm_re       = 1'b1;
          wr_addr_nxt = cnt_r[LM_AW-1:0];
          cnt_nxt     = cnt_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          state_nxt   = S_FRD;
        end
      end
      S_FRD: begin
        lm_re     = 1'b1;
        lm_raddr  = cur_r[LM_AW-1:0];
        state_nxt = S_FOUT;
      end
      S_FOUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = lm_eff;
          out_found_nxt = found_r;
          out_lvl_nxt   = cur_r;
          out_trig_nxt  = trig_r;
          out_stat_nxt  = status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      depth_r     <= '0;
      trig_r      <= '0;
      lm_vld_r    <= '0;
      vl_vld_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      depth_r     <= depth_nxt;
      trig_r      <= trig_nxt;
      lm_vld_r    <= lm_vld_nxt;
      vl_vld_r    <= vl_vld_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r      <= func_nxt;
    vec_r       <= vec_nxt;
    pend_r      <= pend_nxt;
    set_r       <= set_nxt;
    found_r     <= found_nxt;
    status_r    <= status_nxt;
    n_r         <= n_nxt;
    cnt_r       <= cnt_nxt;
    wr_addr_r   <= wr_addr_nxt;
    vl_addr_r   <= vl_addr_nxt;
    out_mask_r  <= out_mask_nxt;
    out_found_r <= out_found_nxt;
    out_lvl_r   <= out_lvl_nxt;
    out_trig_r  <= out_trig_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  plim_ram #(.WIDTH(MASK_W), .DEPTH(NUM_LEVELS)) u_level_masks (
    .clk   (clk),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata),
    .re    (lm_re),
    .raddr (lm_raddr),
    .rdata (lm_q)
  );

  plim_ram #(.WIDTH(LVL_W), .DEPTH(NUM_VECTORS)) u_vector_levels (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_waddr),
    .wdata (vl_wdata),
    .re    (vl_re),
    .raddr (vl_raddr),
    .rdata (vl_q)
  );

  plim_ram #(.WIDTH(LVL_W), .DEPTH(NEST_DEPTH)) u_saved_levels (
    .clk   (clk),
    .we    (sv_we),
    .waddr (sv_waddr),
    .wdata (sv_wdata),
    .re    (sv_re),
    .raddr (sv_raddr),
    .rdata (sv_q)
  );

  assign out_valid             = out_valid_r;
  assign out_enable_mask       = out_mask_r;
  assign out_found_vector      = out_found_r;
  assign out_current_level_out = out_lvl_r;
  assign out_trigger_mask      = out_trig_r;
  assign out_status            = out_stat_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEP_W'(NEST_DEPTH))
    else $error("nesting depth beyond stack size");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= MAX_LVL)
    else $error("current level beyond level count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request accepted while another is in work");

  a_walk_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (lm_we && lm_re) |-> (lm_waddr != lm_raddr))
    else $error("level-mask read and write hit the same entry");

  a_none_no_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NONE)) |-> (out_found_vector == '0))
    else $error("vector reported with nothing pending");

endmodule

`default_nettype wire

### test/plim_result_checker.sv
// Result checker for the priority level interrupt masker: tracks its state and compares beats.
`timescale 1ns / 1ps

module plim_result_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [plim_pkg::FUNC_W-1:0] in_func,
  input  logic [plim_pkg::VEC_W-1:0]  in_vector,
  input  logic [plim_pkg::LVL_W-1:0]  in_level,
  input  logic [plim_pkg::MASK_W-1:0] in_pending_status,
  input  logic                        in_edge_mode,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [plim_pkg::MASK_W-1:0] out_enable_mask,
  input  logic [plim_pkg::VEC_W-1:0]  out_found_vector,
  input  logic [plim_pkg::LVL_W-1:0]  out_current_level_out,
  input  logic [plim_pkg::MASK_W-1:0] out_trigger_mask,
  input  logic [plim_pkg::STAT_W-1:0] out_status,
  output int                          failure_count,
  output int                          answers_due,
  output int                          results_checked
);

  import plim_pkg::*;

  typedef struct packed {
    logic [MASK_W-1:0] enable_mask;
    logic [VEC_W-1:0]  found_vector;
    logic [LVL_W-1:0]  current_level;
    logic [MASK_W-1:0] trigger_mask;
    logic [STAT_W-1:0] status;
  } masker_answer_t;

  // Tracked copy of the block's state.
  logic [LVL_W-1:0]  cur_level;
  logic [LVL_W-1:0]  vec_level [NUM_VECTORS];
  logic [MASK_W-1:0] mask_of_level [NUM_LEVELS];
  logic [MASK_W-1:0] edge_bits;
  logic [LVL_W-1:0]  level_stack [NEST_DEPTH];
  logic [DEP_W-1:0]  stack_depth;

  masker_answer_t predicted_answers [$];
  masker_answer_t oldest_answer;
  int             mismatches = 0;
  int             checked = 0;

  task automatic apply_request(input logic [FUNC_W-1:0] func, input logic [VEC_W-1:0] vec,
                               input logic [LVL_W-1:0] lvl, input logic [MASK_W-1:0] pend,
                               input logic edge_sel);
    logic [MASK_W-1:0] vec_bit;
    logic [MASK_W-1:0] live;
    logic [LVL_W-1:0]  lvl_eff;
    logic [VEC_W-1:0]  first;
    logic              hit;
    masker_answer_t    ans;
    vec_bit     = {1'b1, {(MASK_W-1){1'b0}}} >> vec;
    lvl_eff     = lvl;
    first       = '0;
    hit         = 1'b0;
    ans.status  = ST_OK;
    case (func)
      FN_ENABLE: begin
        if (int'(lvl) > NUM_LEVELS - 1) lvl_eff = LVL_W'(NUM_LEVELS - 1);
        vec_level[vec] = lvl_eff;
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (i < int'(lvl_eff)) mask_of_level[i] |= vec_bit;
        end
      end
      FN_DISABLE: begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (i < int'(vec_level[vec])) mask_of_level[i] &= ~vec_bit;
        end
        vec_level[vec] = '0;
      end
      FN_TRIGGER: begin
        if (edge_sel) edge_bits |= vec_bit;
        else edge_bits &= ~vec_bit;
      end
      FN_ENTRY: begin
        live = pend & VALID_LINES;
        if (live == '0) begin
          ans.status = ST_NONE;
        end else begin
          // Vector 0 is the MSB, so scan down from the top bit.
          for (int i = MASK_W - 1; i >= 0; i--) begin
            if (live[i] && !hit) begin
              first = VEC_W'(MASK_W - 1 - i);
              hit   = 1'b1;
            end
          end
          if (int'(stack_depth) >= NEST_DEPTH) begin
            ans.status = ST_OVF;
          end else begin
            level_stack[stack_depth[SV_AW-1:0]] = cur_level;
            stack_depth = stack_depth + 1'b1;
            if (vec_level[first] > cur_level) cur_level = vec_level[first];
          end
        end
      end
      FN_EXIT: begin
        if (stack_depth == '0) begin
          ans.status = ST_UNF;
        end else begin
          stack_depth = stack_depth - 1'b1;
          cur_level   = level_stack[stack_depth[SV_AW-1:0]];
        end
      end
      default: ;
    endcase
    ans.enable_mask   = mask_of_level[cur_level];
    ans.found_vector  = first;
    ans.current_level = cur_level;
    ans.trigger_mask  = edge_bits;
    predicted_answers.push_back(ans);
  endtask

  task automatic compare_field(input string field, input logic [MASK_W-1:0] want,
                               input logic [MASK_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_level   = '0;
      edge_bits   = '0;
      stack_depth = '0;
      for (int i = 0; i < NUM_VECTORS; i++) vec_level[i] = '0;
      for (int i = 0; i < NUM_LEVELS; i++) mask_of_level[i] = '0;
      predicted_answers.delete();
    end else begin
      // The result of a beat accepted at this edge cannot leave at the same edge,
      // so the output side is checked before the new request is predicted.
      if (out_valid && out_ready) begin
        checked++;
        if (predicted_answers.size() == 0) begin
          $error("result beat arrived with no request waiting for it");
          mismatches++;
        end else begin
          oldest_answer = predicted_answers.pop_front();
          compare_field("enable_mask", oldest_answer.enable_mask, out_enable_mask);
          compare_field("found_vector", MASK_W'(oldest_answer.found_vector),
                        MASK_W'(out_found_vector));
          compare_field("current_level_out", MASK_W'(oldest_answer.current_level),
                        MASK_W'(out_current_level_out));
          compare_field("trigger_mask", oldest_answer.trigger_mask, out_trigger_mask);
          compare_field("status", MASK_W'(oldest_answer.status), MASK_W'(out_status));
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_func, in_vector, in_level, in_pending_status, in_edge_mode);
      end
    end
    failure_count   <= mismatches;
    answers_due     <= predicted_answers.size();
    results_checked <= checked;
  end

endmodule

### test/priority_level_interrupt_masker_tb.sv
// Testbench top for the priority level interrupt masker: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module priority_level_interrupt_masker_tb;
  import plim_pkg::*;

  localparam int RANDOM_REQUESTS = 1000;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 30;
  localparam logic [FUNC_W-1:0] FN_RESERVED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RESERVED_LAST  = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic [VEC_W-1:0]  in_vector = '0;
  logic [LVL_W-1:0]  in_level = '0;
  logic [MASK_W-1:0] in_pending_status = '0;
  logic              in_edge_mode = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MASK_W-1:0] out_enable_mask;
  logic [VEC_W-1:0]  out_found_vector;
  logic [LVL_W-1:0]  out_current_level_out;
  logic [MASK_W-1:0] out_trigger_mask;
  logic [STAT_W-1:0] out_status;

  int failure_count;
  int answers_due;
  int results_checked;

  int sender_idle_pct = 14;
  int receiver_idle_pct = 47;
  logic hold_wanted = 1'b0;
  logic hold_done = 1'b0;
  int random_sent = 0;
  int func_count [8];
  int idle_cycles = 0;

  priority_level_interrupt_masker DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_func               (in_func),
    .in_vector             (in_vector),
    .in_level              (in_level),
    .in_pending_status     (in_pending_status),
    .in_edge_mode          (in_edge_mode),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_enable_mask       (out_enable_mask),
    .out_found_vector      (out_found_vector),
    .out_current_level_out (out_current_level_out),
    .out_trigger_mask      (out_trigger_mask),
    .out_status            (out_status)
  );

  plim_result_checker checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_func               (in_func),
    .in_vector             (in_vector),
    .in_level              (in_level),
    .in_pending_status     (in_pending_status),
    .in_edge_mode          (in_edge_mode),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_enable_mask       (out_enable_mask),
    .out_found_vector      (out_found_vector),
    .out_current_level_out (out_current_level_out),
    .out_trigger_mask      (out_trigger_mask),
    .out_status            (out_status),
    .failure_count         (failure_count),
    .answers_due           (answers_due),
    .results_checked       (results_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Offers one request beat and returns right after the edge that accepts it.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [VEC_W-1:0] vec,
                              input logic [LVL_W-1:0] lvl, input logic [MASK_W-1:0] pend,
                              input logic edge_sel);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_vector         <= vec;
    in_level          <= lvl;
    in_pending_status <= pend;
    in_edge_mode      <= edge_sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    func_count[func]++;
  endtask

  function automatic logic [MASK_W-1:0] random_pending();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return $urandom();
      // Shifting right spreads the first pending line over all vectors.
      default: return MASK_W'($urandom()) >> $urandom_range(MASK_W - 1, 0);
    endcase
  endfunction

  task automatic send_entry();
    send_request(FN_ENTRY, VEC_W'($urandom_range(31, 0)), LVL_W'($urandom_range(15, 0)),
                 random_pending(), 1'($urandom_range(1, 0)));
  endtask

  task automatic send_exit();
    send_request(FN_EXIT, VEC_W'($urandom_range(31, 0)), LVL_W'($urandom_range(15, 0)),
                 $urandom(), 1'($urandom_range(1, 0)));
  endtask

  task automatic random_scenario();
    logic [FUNC_W-1:0] func;
    int                depth;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: begin
        func = FUNC_W'($urandom_range(FN_TRIGGER, FN_ENABLE));
        send_request(func, VEC_W'($urandom_range(31, 0)), LVL_W'($urandom_range(15, 0)),
                     $urandom(), 1'($urandom_range(1, 0)));
        random_sent++;
      end
      4, 5, 6: begin
        depth = $urandom_range(4, 1);
        repeat (depth) send_entry();
        repeat (depth) send_exit();
        random_sent += 2 * depth;
      end
      7: begin
        // Deep nesting of 15 to 20 entries can run past the stack; then the extra exits underflow.
        depth = $urandom_range(20, NEST_DEPTH - 1);
        repeat (depth) send_entry();
        repeat (depth) send_exit();
        random_sent += 2 * depth;
      end
      8: begin
        func = FUNC_W'($urandom_range(FN_RESERVED_LAST, FN_ENABLE));
        send_request(func, VEC_W'($urandom_range(31, 0)), LVL_W'($urandom_range(15, 0)),
                     $urandom(), 1'($urandom_range(1, 0)));
        random_sent++;
      end
      default: begin
        if ($urandom_range(1, 0)) send_entry();
        else send_exit();
        random_sent++;
      end
    endcase
  endtask

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_wanted && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < 8; i++) func_count[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty stack, empty pending word, field extremes, every function.
    send_request(FN_EXIT, 5'd31, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send_request(FN_ENTRY, 5'd31, 4'd15, 32'h0000_0000, 1'b1);
    send_request(FN_ENABLE, 5'd0, 4'd15, 32'h0000_0000, 1'b0);
    send_request(FN_ENABLE, 5'd31, 4'd1, 32'hFFFF_FFFF, 1'b1);
    send_request(FN_ENABLE, 5'd17, 4'd8, 32'h0000_0000, 1'b0);
    send_request(FN_ENABLE, 5'd9, 4'd0, 32'h0000_0000, 1'b0);
    send_request(FN_TRIGGER, 5'd0, 4'd0, 32'h0000_0000, 1'b1);
    send_request(FN_TRIGGER, 5'd31, 4'd15, 32'h0000_0000, 1'b1);
    send_request(FN_TRIGGER, 5'd0, 4'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(FN_ENTRY, 5'd0, 4'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(FN_ENTRY, 5'd0, 4'd0, 32'h0000_0001, 1'b0);
    send_exit();
    send_exit();
    send_request(FN_ENTRY, 5'd0, 4'd0, 32'h8000_0000 >> 17, 1'b0);
    send_exit();
    send_request(FN_DISABLE, 5'd0, 4'd15, 32'h0000_0000, 1'b1);
    send_request(FN_DISABLE, 5'd3, 4'd0, 32'h0000_0000, 1'b0);
    send_request(FN_ENABLE, 5'd17, 4'd3, 32'h0000_0000, 1'b0);
    send_request(FN_DISABLE, 5'd17, 4'd0, 32'h0000_0000, 1'b0);
    send_request(FN_RESERVED_FIRST, 5'd31, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send_request(FN_RESERVED_LAST, 5'd0, 4'd0, 32'h0000_0000, 1'b0);

    while (random_sent < RANDOM_REQUESTS) begin
      if (random_sent >= 2 * RANDOM_REQUESTS / 3) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_wanted       = 1'b1;
      end else if (random_sent >= RANDOM_REQUESTS / 3) begin
        sender_idle_pct   = 47;
        receiver_idle_pct = 14;
      end
      random_scenario();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d enable, %0d disable, %0d trigger, %0d entry, %0d exit and %0d reserved",
             func_count[FN_ENABLE], func_count[FN_DISABLE], func_count[FN_TRIGGER],
             func_count[FN_ENTRY], func_count[FN_EXIT],
             func_count[5] + func_count[6] + func_count[7]);
    $display("requests, %0d result beats compared under three idle mixes and a long stall",
             results_checked);
    if (failure_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
